FILE: design/ut2cal_pkg.sv
`timescale 1ns / 1ps

package ut2cal_pkg;

   localparam int unsigned NUM_STAGES = 9;

   // day and time-of-day split
   localparam logic [16:0] SECONDS_PER_DAY = 17'd86400;
   localparam logic [25:0] RECIP_675       = 26'd50903317;   // 2^35 / 675, rounded up
   localparam logic [15:0] RECIP_15        = 16'd34953;      // 2^19 / 15, rounded up
   localparam logic [16:0] RECIP_7         = 17'd74899;      // 2^19 / 7, rounded up
   localparam logic [5:0]  UNITS_PER_60    = 6'd60;
   localparam logic [2:0]  DAYS_PER_WEEK   = 3'd7;
   localparam logic [1:0]  WEEKDAY_SHIFT   = 2'd3;

   // Julian day number based date
   localparam logic [21:0] JDN_OFFSET      = 22'd2472632;    // 2440588 + 32044
   localparam logic [17:0] DAYS_PER_400Y   = 18'd146097;
   localparam logic [10:0] DAYS_PER_4Y     = 11'd1461;
   localparam logic [18:0] RECIP_1461      = 19'd367469;     // 2^29 / 1461, rounded up
   localparam logic [11:0] RECIP_153       = 12'd3427;       // 2^19 / 153, rounded up
   localparam logic [6:0]  CENT_BASE       = 7'd67;
   localparam logic [23:0] CENT_STEP_LO    = 24'(DAYS_PER_400Y) * 24'(CENT_BASE + 7'd1);
   localparam logic [23:0] CENT_STEP_HI    = 24'(DAYS_PER_400Y) * 24'(CENT_BASE + 7'd2);
   localparam logic [3:0]  MONTH_WRAP      = 4'd10;
   localparam logic [13:0] YEARS_PER_CENT  = 14'd100;
   localparam logic [13:0] YEAR_BIAS       = 14'd4800;

   // (153 * mi + 2) / 5: first day of each month, counted from March
   function automatic logic [8:0] month_start(input logic [3:0] mi);
      logic [8:0] days;
      unique case (mi)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd61;
         4'd3:    days = 9'd92;
         4'd4:    days = 9'd122;
         4'd5:    days = 9'd153;
         4'd6:    days = 9'd184;
         4'd7:    days = 9'd214;
         4'd8:    days = 9'd245;
         4'd9:    days = 9'd275;
         4'd10:   days = 9'd306;
         4'd11:   days = 9'd337;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

FILE: design/unix_time_to_calendar_top.sv
`timescale 1ns / 1ps
// Latency: nine register stages; rsp_valid is the valid bit of the last stage.
// One item per cycle unless stalled; divides are reciprocal multiplies or compares.
// Stages hold their item while downstream is full; empty stages fill behind a stall.
// Reset clears the stage valid bits only; data registers are not reset.
// req_ready is held low while reset is high.

module unix_time_to_calendar_top
   import ut2cal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_epoch_seconds,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_second_of_minute,
   output logic [5:0]  rsp_minute_of_hour,
   output logic [4:0]  rsp_hour_of_day,
   output logic [2:0]  rsp_weekday,
   output logic [4:0]  rsp_day_of_month,
   output logic [3:0]  rsp_month_number,
   output logic [11:0] rsp_full_year
);

   localparam int unsigned LAST = NUM_STAGES - 1;

   logic [NUM_STAGES-1:0] valid_ff, valid_in, stage_ready;

   always_comb begin
      stage_ready[LAST] = !valid_ff[LAST] || rsp_ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      valid_in[0] = stage_ready[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = stage_ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_ready[0] && !reset;
   assign rsp_valid = valid_ff[LAST];

   // stage 1: seconds / 86400 as (t >> 7) / 675
   logic [50:0] s1_prod_ff, s1_prod_in;
   logic [31:0] s1_t_ff, s1_t_in;

   assign s1_prod_in = 51'(req_epoch_seconds[31:7]) * 51'(RECIP_675);
   assign s1_t_in    = req_epoch_seconds;

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         s1_prod_ff <= s1_prod_in;
         s1_t_ff    <= s1_t_in;
      end
   end

   // stage 2: day count
   logic [15:0] s2_days_ff, s2_days_in;
   logic [15:0] s2_wd_ff, s2_wd_in;
   logic [31:0] s2_t_ff, s2_t_in;

   assign s2_days_in = s1_prod_ff[50:35];
   assign s2_wd_in   = s1_prod_ff[50:35] + 16'(WEEKDAY_SHIFT);
   assign s2_t_in    = s1_t_ff;

   always_ff @(posedge clock) begin
      if (stage_ready[1]) begin
         s2_days_ff <= s2_days_in;
         s2_wd_ff   <= s2_wd_in;
         s2_t_ff    <= s2_t_in;
      end
   end

   // stage 3: time of day, century, weekday product
   logic [16:0] s3_tod_ff, s3_tod_in;
   logic [21:0] s3_a0_ff, s3_a0_in;
   logic [6:0]  s3_cent_ff, s3_cent_in;
   logic [15:0] s3_wd_ff, s3_wd_in;
   logic [32:0] s3_wk_prod_ff, s3_wk_prod_in;
   logic [23:0] s3_cent_x;

   always_comb begin
      s3_tod_in     = 17'(s2_t_ff - (32'(s2_days_ff) * 32'(SECONDS_PER_DAY)));
      s3_a0_in      = 22'(s2_days_ff) + JDN_OFFSET;
      s3_cent_x     = {s3_a0_in, 2'b11};
      s3_cent_in    = CENT_BASE + 7'(s3_cent_x >= CENT_STEP_LO)
                                + 7'(s3_cent_x >= CENT_STEP_HI);
      s3_wd_in      = s2_wd_ff;
      s3_wk_prod_in = 33'(s2_wd_ff) * 33'(RECIP_7);
   end

   always_ff @(posedge clock) begin
      if (stage_ready[2]) begin
         s3_tod_ff     <= s3_tod_in;
         s3_a0_ff      <= s3_a0_in;
         s3_cent_ff    <= s3_cent_in;
         s3_wd_ff      <= s3_wd_in;
         s3_wk_prod_ff <= s3_wk_prod_in;
      end
   end

   // stage 4: minutes product, weekday, day within 400-year cycle
   logic [30:0] s4_mins_prod_ff, s4_mins_prod_in;
   logic [16:0] s4_tod_ff, s4_tod_in;
   logic [2:0]  s4_weekday_ff, s4_weekday_in;
   logic [15:0] s4_a1_ff, s4_a1_in;
   logic [6:0]  s4_cent_ff, s4_cent_in;
   logic [15:0] s4_q7;

   always_comb begin
      s4_mins_prod_in = 31'(s3_tod_ff[16:2]) * 31'(RECIP_15);
      s4_tod_in       = s3_tod_ff;
      s4_q7           = 16'(s3_wk_prod_ff[32:19]);
      s4_weekday_in   = 3'(s3_wd_ff - s4_q7 * 16'(DAYS_PER_WEEK));
      s4_a1_in        = 16'(s3_a0_ff
                        - 22'((24'(DAYS_PER_400Y) * 24'(s3_cent_ff)) >> 2));
      s4_cent_in      = s3_cent_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_ready[3]) begin
         s4_mins_prod_ff <= s4_mins_prod_in;
         s4_tod_ff       <= s4_tod_in;
         s4_weekday_ff   <= s4_weekday_in;
         s4_a1_ff        <= s4_a1_in;
         s4_cent_ff      <= s4_cent_in;
      end
   end

   // stage 5: minutes, seconds, four-year product
   logic [10:0] s5_mins_ff, s5_mins_in;
   logic [5:0]  s5_sec_ff, s5_sec_in;
   logic [36:0] s5_quad_prod_ff, s5_quad_prod_in;
   logic [15:0] s5_a1_ff, s5_a1_in;
   logic [6:0]  s5_cent_ff, s5_cent_in;
   logic [2:0]  s5_weekday_ff, s5_weekday_in;

   always_comb begin
      s5_mins_in      = s4_mins_prod_ff[29:19];
      s5_sec_in       = 6'(s4_tod_ff - 17'(s5_mins_in) * 17'(UNITS_PER_60));
      s5_quad_prod_in = 37'({s4_a1_ff, 2'b11}) * 37'(RECIP_1461);
      s5_a1_in        = s4_a1_ff;
      s5_cent_in      = s4_cent_ff;
      s5_weekday_in   = s4_weekday_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_ready[4]) begin
         s5_mins_ff      <= s5_mins_in;
         s5_sec_ff       <= s5_sec_in;
         s5_quad_prod_ff <= s5_quad_prod_in;
         s5_a1_ff        <= s5_a1_in;
         s5_cent_ff      <= s5_cent_in;
         s5_weekday_ff   <= s5_weekday_in;
      end
   end

   // stage 6: hours product, four-year count
   logic [24:0] s6_hour_prod_ff, s6_hour_prod_in;
   logic [6:0]  s6_quad_ff, s6_quad_in;
   logic [10:0] s6_mins_ff, s6_mins_in;
   logic [5:0]  s6_sec_ff, s6_sec_in;
   logic [15:0] s6_a1_ff, s6_a1_in;
   logic [6:0]  s6_cent_ff, s6_cent_in;
   logic [2:0]  s6_weekday_ff, s6_weekday_in;

   always_comb begin
      s6_hour_prod_in = 25'(s5_mins_ff[10:2]) * 25'(RECIP_15);
      s6_quad_in      = s5_quad_prod_ff[35:29];
      s6_mins_in      = s5_mins_ff;
      s6_sec_in       = s5_sec_ff;
      s6_a1_in        = s5_a1_ff;
      s6_cent_in      = s5_cent_ff;
      s6_weekday_in   = s5_weekday_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_ready[5]) begin
         s6_hour_prod_ff <= s6_hour_prod_in;
         s6_quad_ff      <= s6_quad_in;
         s6_mins_ff      <= s6_mins_in;
         s6_sec_ff       <= s6_sec_in;
         s6_a1_ff        <= s6_a1_in;
         s6_cent_ff      <= s6_cent_in;
         s6_weekday_ff   <= s6_weekday_in;
      end
   end

   // stage 7: hour, minute, day within the March-based year
   logic [4:0] s7_hour_ff, s7_hour_in;
   logic [5:0] s7_minute_ff, s7_minute_in;
   logic [8:0] s7_a2_ff, s7_a2_in;
   logic [5:0] s7_sec_ff, s7_sec_in;
   logic [6:0] s7_quad_ff, s7_quad_in;
   logic [6:0] s7_cent_ff, s7_cent_in;
   logic [2:0] s7_weekday_ff, s7_weekday_in;

   always_comb begin
      s7_hour_in    = s6_hour_prod_ff[23:19];
      s7_minute_in  = 6'(s6_mins_ff - 11'(s7_hour_in) * 11'(UNITS_PER_60));
      s7_a2_in      = 9'(s6_a1_ff
                      - 16'((18'(DAYS_PER_4Y) * 18'(s6_quad_ff)) >> 2));
      s7_sec_in     = s6_sec_ff;
      s7_quad_in    = s6_quad_ff;
      s7_cent_in    = s6_cent_ff;
      s7_weekday_in = s6_weekday_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_ready[6]) begin
         s7_hour_ff    <= s7_hour_in;
         s7_minute_ff  <= s7_minute_in;
         s7_a2_ff      <= s7_a2_in;
         s7_sec_ff     <= s7_sec_in;
         s7_quad_ff    <= s7_quad_in;
         s7_cent_ff    <= s7_cent_in;
         s7_weekday_ff <= s7_weekday_in;
      end
   end

   // stage 8: month product
   logic [22:0] s8_mi_prod_ff, s8_mi_prod_in;
   logic [8:0]  s8_a2_ff, s8_a2_in;
   logic [4:0]  s8_hour_ff, s8_hour_in;
   logic [5:0]  s8_minute_ff, s8_minute_in;
   logic [5:0]  s8_sec_ff, s8_sec_in;
   logic [6:0]  s8_quad_ff, s8_quad_in;
   logic [6:0]  s8_cent_ff, s8_cent_in;
   logic [2:0]  s8_weekday_ff, s8_weekday_in;
   logic [10:0] s8_mi_x;

   always_comb begin
      s8_mi_x       = 11'(s7_a2_ff) * 11'd5 + 11'd2;
      s8_mi_prod_in = 23'(s8_mi_x) * 23'(RECIP_153);
      s8_a2_in      = s7_a2_ff;
      s8_hour_in    = s7_hour_ff;
      s8_minute_in  = s7_minute_ff;
      s8_sec_in     = s7_sec_ff;
      s8_quad_in    = s7_quad_ff;
      s8_cent_in    = s7_cent_ff;
      s8_weekday_in = s7_weekday_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_ready[7]) begin
         s8_mi_prod_ff <= s8_mi_prod_in;
         s8_a2_ff      <= s8_a2_in;
         s8_hour_ff    <= s8_hour_in;
         s8_minute_ff  <= s8_minute_in;
         s8_sec_ff     <= s8_sec_in;
         s8_quad_ff    <= s8_quad_in;
         s8_cent_ff    <= s8_cent_in;
         s8_weekday_ff <= s8_weekday_in;
      end
   end

   // stage 9: day, month, year; output register
   logic [5:0]  s9_sec_ff, s9_sec_in;
   logic [5:0]  s9_minute_ff, s9_minute_in;
   logic [4:0]  s9_hour_ff, s9_hour_in;
   logic [2:0]  s9_weekday_ff, s9_weekday_in;
   logic [4:0]  s9_dom_ff, s9_dom_in;
   logic [3:0]  s9_month_ff, s9_month_in;
   logic [11:0] s9_year_ff, s9_year_in;
   logic [3:0]  s9_mi;
   logic        s9_wrap;

   always_comb begin
      s9_mi         = s8_mi_prod_ff[22:19];
      s9_wrap       = s9_mi >= MONTH_WRAP;
      s9_dom_in     = 5'(s8_a2_ff - month_start(s9_mi) + 9'd1);
      s9_month_in   = s9_wrap ? (s9_mi - 4'd9) : (s9_mi + 4'd3);
      s9_year_in    = 12'(14'(s8_cent_ff) * YEARS_PER_CENT + 14'(s8_quad_ff)
                      + 14'(s9_wrap) - YEAR_BIAS);
      s9_sec_in     = s8_sec_ff;
      s9_minute_in  = s8_minute_ff;
      s9_hour_in    = s8_hour_ff;
      s9_weekday_in = s8_weekday_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_ready[8]) begin
         s9_sec_ff     <= s9_sec_in;
         s9_minute_ff  <= s9_minute_in;
         s9_hour_ff    <= s9_hour_in;
         s9_weekday_ff <= s9_weekday_in;
         s9_dom_ff     <= s9_dom_in;
         s9_month_ff   <= s9_month_in;
         s9_year_ff    <= s9_year_in;
      end
   end

   assign rsp_second_of_minute = s9_sec_ff;
   assign rsp_minute_of_hour   = s9_minute_ff;
   assign rsp_hour_of_day      = s9_hour_ff;
   assign rsp_weekday          = s9_weekday_ff;
   assign rsp_day_of_month     = s9_dom_ff;
   assign rsp_month_number     = s9_month_ff;
   assign rsp_full_year        = s9_year_ff;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam logic [63:0] DAY_SECONDS  = 64'd86400;
   localparam logic [63:0] JDN_EPOCH    = 64'd2440588;
   localparam logic [63:0] JDN_SHIFT    = 64'd32044;
   localparam logic [63:0] ERA_DAYS     = 64'd146097;
   localparam logic [63:0] QUAD_DAYS    = 64'd1461;
   localparam logic [63:0] MONTH_SPAN   = 64'd153;
   localparam logic [63:0] YEAR_OFFSET  = 64'd4800;
   localparam int          PHASE_ITEMS  = 417;
   localparam int          DRAIN_CYCLES = 20;
   localparam int          REPORT_LIMIT = 10;

   typedef struct packed {
      logic [5:0]  second_of_minute;
      logic [5:0]  minute_of_hour;
      logic [4:0]  hour_of_day;
      logic [2:0]  weekday;
      logic [4:0]  day_of_month;
      logic [3:0]  month_number;
      logic [11:0] full_year;
   } calendar_type;

   function automatic calendar_type to_calendar(input logic [31:0] secs);
      logic [63:0]  days, tod, a, cent, quad, mi, dom, mon, yr;
      calendar_type c;
      days = 64'(secs) / DAY_SECONDS;
      tod  = 64'(secs) % DAY_SECONDS;
      a    = days + JDN_EPOCH + JDN_SHIFT;
      cent = (64'd4 * a + 64'd3) / ERA_DAYS;
      a    = a - (ERA_DAYS * cent) / 64'd4;
      quad = (64'd4 * a + 64'd3) / QUAD_DAYS;
      a    = a - (QUAD_DAYS * quad) / 64'd4;
      mi   = (64'd5 * a + 64'd2) / MONTH_SPAN;
      dom  = a - (MONTH_SPAN * mi + 64'd2) / 64'd5 + 64'd1;
      mon  = mi + 64'd3 - 64'd12 * (mi / 64'd10);
      yr   = 64'd100 * cent + quad + mi / 64'd10 - YEAR_OFFSET;
      c.second_of_minute = 6'(tod % 64'd60);
      c.minute_of_hour   = 6'((tod % 64'd3600) / 64'd60);
      c.hour_of_day      = 5'(tod / 64'd3600);
      c.weekday          = 3'((days + 64'd3) % 64'd7);
      c.day_of_month     = 5'(dom);
      c.month_number     = 4'(mon);
      c.full_year        = 12'(yr);
      return c;
   endfunction

   class calendar_ledger;
      calendar_type due_dates[$];
      logic [31:0] due_epochs[$];
      int failures;

      function new();
         failures = 0;
      endfunction

      function void note_epoch(input logic [31:0] secs);
         due_dates.push_back(to_calendar(secs));
         due_epochs.push_back(secs);
      endfunction

      function void check_calendar(input calendar_type got);
         calendar_type want;
         logic [31:0]  secs;
         if (due_dates.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected result item %0d:%0d:%0d wd %0d %0d-%0d-%0d",
                        got.hour_of_day, got.minute_of_hour, got.second_of_minute,
                        got.weekday, got.full_year, got.month_number, got.day_of_month);
            return;
         end
         want = due_dates.pop_front();
         secs = due_epochs.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display({"mismatch for %0d: exp %0d:%0d:%0d wd %0d %0d-%0d-%0d, ",
                         "got %0d:%0d:%0d wd %0d %0d-%0d-%0d"},
                        secs,
                        want.hour_of_day, want.minute_of_hour, want.second_of_minute,
                        want.weekday, want.full_year, want.month_number, want.day_of_month,
                        got.hour_of_day, got.minute_of_hour, got.second_of_minute,
                        got.weekday, got.full_year, got.month_number, got.day_of_month);
         end
      endfunction

      function int pending();
         return due_dates.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_epoch_seconds = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_second_of_minute;
   logic [5:0]  rsp_minute_of_hour;
   logic [4:0]  rsp_hour_of_day;
   logic [2:0]  rsp_weekday;
   logic [4:0]  rsp_day_of_month;
   logic [3:0]  rsp_month_number;
   logic [11:0] rsp_full_year;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   calendar_ledger ledger = new();

   unix_time_to_calendar_top u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_epoch_seconds    (req_epoch_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_second_of_minute (rsp_second_of_minute),
      .rsp_minute_of_hour   (rsp_minute_of_hour),
      .rsp_hour_of_day      (rsp_hour_of_day),
      .rsp_weekday          (rsp_weekday),
      .rsp_day_of_month     (rsp_day_of_month),
      .rsp_month_number     (rsp_month_number),
      .rsp_full_year        (rsp_full_year)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         ledger.check_calendar('{rsp_second_of_minute, rsp_minute_of_hour, rsp_hour_of_day,
                                 rsp_weekday, rsp_day_of_month, rsp_month_number,
                                 rsp_full_year});
   end

   task automatic send_epoch(input logic [31:0] secs);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_epoch_seconds <= $urandom();
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_epoch_seconds <= secs;
      do @(posedge clock); while (!req_ready);
      ledger.note_epoch(secs);
   endtask

   function automatic logic [31:0] random_epoch();
      logic [31:0] day_n;
      day_n = $urandom_range(0, 49709);
      case ($urandom_range(0, 5))
         0, 1, 2: return $urandom();
         3:       return day_n * 32'd86400;
         4:       return day_n * 32'd86400 + 32'd86399;
         default: return 32'hFFFF_FFFF - $urandom_range(0, 200000);
      endcase
   endfunction

   logic [31:0] directed[$] = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd68169600,            // 1972-02-29
      32'd94694399,            // end of 1972
      32'd951782400,           // 2000-02-29
      32'd951868800,
      32'd4102444799,          // end of 2099
      32'd4107456000,          // 2100-02-28, no leap day
      32'd4107542400,
      32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
      32'd4294944000, 32'hFFFF_FFFE, 32'hFFFF_FFFF
   };

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct  = 18;
      recv_stall_pct = 59;
      foreach (directed[i]) send_epoch(directed[i]);
      repeat (PHASE_ITEMS) send_epoch(random_epoch());

      send_idle_pct  = 59;
      recv_stall_pct = 18;
      repeat (PHASE_ITEMS) send_epoch(random_epoch());

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (PHASE_ITEMS) send_epoch(random_epoch());
      req_valid <= 1'b0;

      while (ledger.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (ledger.failures == 0 && ledger.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule
